// ===== hdl/tpgd_pkg.sv =====
`timescale 1ns / 1ps

package tpgd_pkg;

	// Detector sizing.
	localparam int MAX_STRIDE   = 256;
	localparam int MAX_RUNS     = 5;
	localparam int HISTORY_BITS = 1024;

	// Taps looked back per stride: one fewer than the longest run.
	localparam int TAPS    = MAX_RUNS - 1;
	localparam int HIST_AW = $clog2(HISTORY_BITS);
	localparam int MAX_LAG = (TAPS * MAX_STRIDE > HISTORY_BITS) ? TAPS * MAX_STRIDE
		: HISTORY_BITS;
	localparam int LAG_W   = $clog2(MAX_LAG + 1);
	localparam int STRIDES = 3;

	// Field and register widths.
	localparam int BYTE_W     = 8;
	localparam int STRIDE_W   = 9;
	localparam int RUNS_W     = 3;
	localparam int LIMIT_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int OUT_DATA_W = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_RUNS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT    = 3'd5;

	// Register reset values.
	localparam logic [STRIDE_W-1:0] RST_STRIDE_FIRST  = 9'd188;
	localparam logic [STRIDE_W-1:0] RST_STRIDE_SECOND = 9'd192;
	localparam logic [STRIDE_W-1:0] RST_STRIDE_THIRD  = 9'd204;
	localparam logic [RUNS_W-1:0]   RST_SYNC_RUNS     = 3'd5;
	localparam logic [BYTE_W-1:0]   RST_SYNC_VALUE    = 8'h47;
	localparam logic [LIMIT_W-1:0]  RST_SCAN_LIMIT    = 17'd65536;

	// Shared control from the top level to every stride checker.
	typedef struct packed {
		logic               wr_en;
		logic               rd_en;
		logic               flag;
		logic [HIST_AW-1:0] wpos;
		logic [LAG_W-1:0]   fill;
	} hist_ctrl_t;

endpackage

// ===== hdl/tpgd_ram.sv =====
`timescale 1ns / 1ps

module tpgd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when both ports hit the same entry.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== hdl/tpgd_stride_taps.sv =====
`timescale 1ns / 1ps

module tpgd_stride_taps (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tpgd_pkg::STRIDE_W-1:0] stride,
	input  logic [tpgd_pkg::TAPS-1:0]     need,
	input  tpgd_pkg::hist_ctrl_t          hist,
	output logic                          hit
);

	import tpgd_pkg::*;

	logic [LAG_W-1:0] stride_eff;
	logic [TAPS-1:0]  tap_data;
	logic [TAPS-1:0]  tap_valid_s1;

	// Strides above the history reach are clamped to the largest one.
	always_comb begin
		if (LAG_W'(stride) > LAG_W'(MAX_STRIDE)) begin
			stride_eff = LAG_W'(MAX_STRIDE);
		end else begin
			stride_eff = LAG_W'(stride);
		end
	end

	// One flag copy per tap, each read one, two, ... strides back.
	for (genvar i = 0; i < TAPS; i++) begin : g_tap
		logic [LAG_W-1:0]   lag;
		logic [HIST_AW-1:0] raddr;

		assign lag   = LAG_W'(stride_eff * (i + 1));
		assign raddr = hist.wpos - lag[HIST_AW-1:0];

		tpgd_ram #(
			.WIDTH(1),
			.DEPTH(HISTORY_BITS)
		) u_ram (
			.clk  (clk),
			.we   (hist.wr_en),
			.waddr(hist.wpos),
			.wdata(hist.flag),
			.re   (hist.rd_en),
			.raddr(raddr),
			.rdata(tap_data[i])
		);

		// A tap older than the first byte of this head reads as no sync.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tap_valid_s1[i] <= 1'b0;
			end else if (hist.rd_en) begin
				tap_valid_s1[i] <= (lag <= hist.fill);
			end
		end
	end

	// Every tap the run length asks for must carry a sync byte.
	assign hit = (stride != '0) && (&((tap_data & tap_valid_s1) | ~need));

endmodule

// ===== hdl/ts_packet_grid_detector.sv =====
`timescale 1ns / 1ps

// Transport-stream packet grid detector. Bytes of a file head enter on the s_ stream, one per
// clock while s_tready is high, with no gaps needed; the beat marked by s_tlast gives one
// verdict beat on the m_ stream, registered in stage one and then in the output register
// (m_tdata bit 0 set when the sync value recurred at one configured stride the configured
// number of times in a row) and clears the scan state for the next head. The sync-flag
// history sits in three sets of four 1024 x 1 RAMs, one RAM per look-back tap, all read in the
// cycle the byte is taken, and the taps are combined in the single stage behind them.
// s_tready falls only while a verdict waits behind a full output register.
// A fill count masks history older than the current head, so there is no clearing pass after
// reset or after a verdict. The user writes registers on the cfg_ port only between heads or
// between bytes while nothing is in flight, unchecked by the block; cfg_ready is always high.
module ts_packet_grid_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpgd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tpgd_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] byte_value
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tpgd_pkg::OUT_DATA_W-1:0] m_tdata   // [0] grid_found, [7:1] zero
);

	import tpgd_pkg::*;

	logic [STRIDE_W-1:0] stride_first_q;
	logic [STRIDE_W-1:0] stride_second_q;
	logic [STRIDE_W-1:0] stride_third_q;
	logic [RUNS_W-1:0]   sync_runs_q;
	logic [BYTE_W-1:0]   sync_value_q;
	logic [LIMIT_W-1:0]  scan_limit_q;

	logic [HIST_AW-1:0]  wpos_q;
	logic [LAG_W-1:0]    fill_q;
	logic [LIMIT_W-1:0]  bytes_seen_q;
	logic                found_q;

	logic                valid_s1;
	logic                last_s1;
	logic                check_s1;

	logic                out_valid_q;
	logic                grid_found_q;

	logic                accept;
	logic                examine;
	logic                flag;
	logic                out_free;
	logic                s1_adv;
	logic                found_next;
	logic [RUNS_W:0]     runs_eff;
	logic [TAPS-1:0]     need;
	logic [STRIDES-1:0]  stride_hit;
	logic [STRIDE_W-1:0] stride_sel [STRIDES];
	hist_ctrl_t          hist;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_first_q  <= RST_STRIDE_FIRST;
			stride_second_q <= RST_STRIDE_SECOND;
			stride_third_q  <= RST_STRIDE_THIRD;
			sync_runs_q     <= RST_SYNC_RUNS;
			sync_value_q    <= RST_SYNC_VALUE;
			scan_limit_q    <= RST_SCAN_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STRIDE_FIRST:  stride_first_q  <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_SECOND: stride_second_q <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_THIRD:  stride_third_q  <= cfg_data[STRIDE_W-1:0];
				REG_SYNC_RUNS:     sync_runs_q     <= cfg_data[RUNS_W-1:0];
				REG_SYNC_VALUE:    sync_value_q    <= cfg_data[BYTE_W-1:0];
				REG_SCAN_LIMIT:    scan_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the stage moves on unless a verdict is blocked by a full output.
	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = !valid_s1 || !last_s1 || out_free;
	assign s_tready = s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Bytes past the scan limit are not examined.
	assign examine = bytes_seen_q < scan_limit_q;
	assign flag    = s_tdata == sync_value_q;

	// History position and counts, cleared by the last beat of a head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q       <= '0;
			fill_q       <= '0;
			bytes_seen_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				wpos_q       <= '0;
				fill_q       <= '0;
				bytes_seen_q <= '0;
			end else if (examine) begin
				wpos_q       <= wpos_q + 1'b1;
				bytes_seen_q <= bytes_seen_q + 1'b1;
				if (fill_q != LAG_W'(HISTORY_BITS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	assign hist.wr_en = accept && examine;
	assign hist.rd_en = accept;
	assign hist.flag  = flag;
	assign hist.wpos  = wpos_q;
	assign hist.fill  = fill_q;

	// Run length clamped into its legal range; tap i is needed while i + 1 < runs.
	always_comb begin
		if (sync_runs_q < RUNS_W'(2)) begin
			runs_eff = (RUNS_W + 1)'(2);
		end else if ((RUNS_W + 1)'(sync_runs_q) > (RUNS_W + 1)'(MAX_RUNS)) begin
			runs_eff = (RUNS_W + 1)'(MAX_RUNS);
		end else begin
			runs_eff = (RUNS_W + 1)'(sync_runs_q);
		end
		for (int i = 0; i < TAPS; i++) begin
			need[i] = (RUNS_W + 1)'(i + 1) < runs_eff;
		end
	end

	assign stride_sel[0] = stride_first_q;
	assign stride_sel[1] = stride_second_q;
	assign stride_sel[2] = stride_third_q;

	// One checker per configured stride.
	for (genvar s = 0; s < STRIDES; s++) begin : g_stride
		tpgd_stride_taps u_taps (
			.clk   (clk),
			.arst_n(arst_n),
			.stride(stride_sel[s]),
			.need  (need),
			.hist  (hist),
			.hit   (stride_hit[s])
		);
	end

	// Stage one: the byte waits here while its taps come out of the RAMs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= s_tlast;
			check_s1 <= examine && flag;
		end
	end

	// Sticky verdict, cleared once it has been handed to the output.
	assign found_next = found_q || (valid_s1 && check_s1 && (|stride_hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			found_q <= last_s1 ? 1'b0 : found_next;
		end
	end

	// Output register for the verdict beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			grid_found_q <= found_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - 1)'(0), grid_found_q};

endmodule
